// ===== src/binary_min_heap_queue_defines.svh =====
// binary_min_heap_queue_defines.svh: assertion macros for the heap queue.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define BMHQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bmhq property violated");
// condition that must never be seen out of reset
`define BMHQ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bmhq forbidden condition seen");
`else
`define BMHQ_ASSERT(lbl, prop)
`define BMHQ_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/bmhq_pkg.sv =====
// bmhq_pkg: command, status and compare codes plus the control structs
// shared by the heap queue modules. No dependencies.
package bmhq_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] cmp_sel_t;

  // command codes
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // operand selections of the shared compare unit
  localparam cmp_sel_t CMP_UP   = 2'd0;  // moving key < parent
  localparam cmp_sel_t CMP_PICK = 2'd1;  // right child < left child
  localparam cmp_sel_t CMP_DOWN = 2'd2;  // smaller child < moving key

  localparam logic [7:0] CAP_RESET = 8'd255;

  // top level to engine
  typedef struct packed {
    logic start;
    logic res_take;
    cmd_t command;
  } bmhq_req_t;

  // engine to top level
  typedef struct packed {
    logic    idle;
    logic    done;
    status_t status;
  } bmhq_stat_t;

endpackage

// ===== src/bmhq_if.sv =====
// bmhq_if: valid/ready channels for command words and result words.
// Depends on nothing; KEY_WIDTH sets the key fields.
interface bmhq_cmd_if #(
  parameter int unsigned KEY_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [KEY_WIDTH-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface bmhq_res_if #(
  parameter int unsigned KEY_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic signed [KEY_WIDTH-1:0] min_value;
  logic [7:0]                  entry_count;

  modport source (output valid, status, min_value, entry_count, input ready);
  modport sink   (input valid, status, min_value, entry_count, output ready);
endinterface

// ===== src/bmhq_key_cmp.sv =====
// bmhq_key_cmp: the one signed key comparator, with its operand selection.
// Depends on bmhq_pkg for the compare selection codes.
module bmhq_key_cmp #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  bmhq_pkg::cmp_sel_t   sel_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [KEY_WIDTH-1:0] rd_i,
  input  logic [KEY_WIDTH-1:0] cand_i,
  output logic                 lt_o
);
  import bmhq_pkg::*;

  logic [KEY_WIDTH-1:0] op_a, op_b;

  // route the operands for the current step
  always_comb begin
    case (sel_i)
      CMP_UP: begin
        op_a = key_i;
        op_b = rd_i;
      end
      CMP_PICK: begin
        op_a = rd_i;
        op_b = cand_i;
      end
      default: begin
        op_a = cand_i;
        op_b = key_i;
      end
    endcase
  end

  // strict signed less-than: equal keys never move
  assign lt_o = $signed(op_a) < $signed(op_b);

endmodule

// ===== src/bmhq_engine.sv =====
// bmhq_engine: heap store, entry count and the sift sequencer around the
// shared comparator. Depends on bmhq_pkg, bmhq_key_cmp and the defines header.
`include "binary_min_heap_queue_defines.svh"

module bmhq_engine #(
  parameter int unsigned MAX_ENTRIES = 255,
  parameter int unsigned KEY_WIDTH   = 32,
  localparam int unsigned ADDR_W     = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmhq_pkg::bmhq_req_t   req_i,
  input  logic [KEY_WIDTH-1:0]  key_i,
  input  logic [7:0]            cap_i,
  output bmhq_pkg::bmhq_stat_t  stat_o,
  output logic [KEY_WIDTH-1:0]  min_value_o,
  output logic [7:0]            entry_count_o
);
  import bmhq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_ROOT    = 4'd3;
  localparam logic [3:0] S_LAST    = 4'd4;
  localparam logic [3:0] S_DN_L    = 4'd5;
  localparam logic [3:0] S_DN_R    = 4'd6;
  localparam logic [3:0] S_DN_PICK = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [ADDR_W-1:0]    count_q, count_d;
  logic [ADDR_W-1:0]    slot_q, slot_d;
  logic [ADDR_W-1:0]    cidx_q, cidx_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] cand_q, cand_d;
  logic [KEY_WIDTH-1:0] min_q, min_d;
  status_t              status_q, status_d;
  logic                 del_q, del_d;

  logic [KEY_WIDTH-1:0] mem_q [0:MAX_ENTRIES];
  logic [KEY_WIDTH-1:0] rd_q;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic                 we;

  logic [ADDR_W:0]      lchild, rchild, cnt_ext;
  logic [ADDR_W+7:0]    cnt_wide;
  logic                 full;
  logic                 lt;
  cmp_sel_t             cmp_sel;

  assign lchild  = {slot_q, 1'b0};
  assign rchild  = {slot_q, 1'b1};
  assign cnt_ext = {1'b0, count_q};

  // full when the count reaches the written capacity or the store depth
  assign full = ({8'b0, count_q} >= {{ADDR_W{1'b0}}, cap_i}) ||
                (count_q >= ADDR_W'(MAX_ENTRIES));

  bmhq_key_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .sel_i  (cmp_sel),
    .key_i  (key_q),
    .rd_i   (rd_q),
    .cand_i (cand_q),
    .lt_o   (lt)
  );

  // sequencer: one memory read and at most one compare per cycle
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    slot_d   = slot_q;
    cidx_d   = cidx_q;
    key_d    = key_q;
    cand_d   = cand_q;
    min_d    = min_q;
    status_d = status_q;
    del_d    = del_q;
    we       = 1'b0;
    waddr    = slot_q;
    wdata    = key_q;
    raddr    = '0;
    cmp_sel  = CMP_UP;

    unique case (state_q)
      S_IDLE: begin
        raddr = ADDR_W'(1);
        if (req_i.start) begin
          min_d    = '0;
          status_d = ST_OK;
          key_d    = key_i;
          del_d    = (req_i.command == CMD_DELETE);
          unique case (req_i.command) inside
            CMD_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                slot_d  = count_q + ADDR_W'(1);
                state_d = S_UP_RD;
              end
            end
            CMD_DELETE, CMD_READ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_ROOT;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_UP_RD: begin
        raddr = slot_q >> 1;
        if (slot_q == ADDR_W'(1)) begin
          we      = 1'b1;
          count_d = count_q + ADDR_W'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_UP_CMP;
        end
      end

      // parent is in rd_q: pull it down or settle the key here
      S_UP_CMP: begin
        cmp_sel = CMP_UP;
        we      = 1'b1;
        if (lt) begin
          wdata   = rd_q;
          slot_d  = slot_q >> 1;
          state_d = S_UP_RD;
        end else begin
          count_d = count_q + ADDR_W'(1);
          state_d = S_DONE;
        end
      end

      // root is in rd_q; fetch the last entry for a delete
      S_ROOT: begin
        raddr = count_q;
        min_d = rd_q;
        if (!del_q) begin
          state_d = S_DONE;
        end else if (count_q == ADDR_W'(1)) begin
          we      = 1'b1;
          waddr   = ADDR_W'(1);
          wdata   = '0;
          count_d = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_LAST;
        end
      end

      S_LAST: begin
        key_d   = rd_q;
        count_d = count_q - ADDR_W'(1);
        slot_d  = ADDR_W'(1);
        state_d = S_DN_L;
      end

      S_DN_L: begin
        raddr = lchild[ADDR_W-1:0];
        if (lchild <= cnt_ext) begin
          state_d = S_DN_R;
        end else begin
          we      = 1'b1;
          state_d = S_DONE;
        end
      end

      S_DN_R: begin
        raddr  = rchild[ADDR_W-1:0];
        cand_d = rd_q;
        cidx_d = lchild[ADDR_W-1:0];
        state_d = (rchild <= cnt_ext) ? S_DN_PICK : S_DN_CMP;
      end

      // keep the right child only when strictly smaller
      S_DN_PICK: begin
        cmp_sel = CMP_PICK;
        if (lt) begin
          cand_d = rd_q;
          cidx_d = rchild[ADDR_W-1:0];
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_sel = CMP_DOWN;
        we      = 1'b1;
        if (lt) begin
          wdata   = cand_q;
          slot_d  = cidx_q;
          state_d = S_DN_L;
        end else begin
          state_d = S_DONE;
        end
      end

      // hold the result until the output register is free
      S_DONE: begin
        if (req_i.res_take) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    cidx_q   <= cidx_d;
    key_q    <= key_d;
    cand_q   <= cand_d;
    min_q    <= min_d;
    status_q <= status_d;
    del_q    <= del_d;
  end

  // heap store: at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  assign cnt_wide      = {8'b0, count_q};
  assign entry_count_o = cnt_wide[7:0];
  assign min_value_o   = min_q;
  assign stat_o.idle   = (state_q == S_IDLE);
  assign stat_o.done   = (state_q == S_DONE);
  assign stat_o.status = status_q;

  `BMHQ_ASSERT_NEVER(a_count_max, count_q > MAX_ENTRIES)
  `BMHQ_ASSERT(a_start_idle, req_i.start |-> state_q == S_IDLE)
  `BMHQ_ASSERT(a_count_step, !$stable(count_q) |-> (count_q == $past(count_q) + 1 || count_q == $past(count_q) - 1))
  `BMHQ_ASSERT(a_empty_count, (state_q == S_DONE && status_q == ST_EMPTY) |-> count_q == '0)
  `BMHQ_ASSERT_NEVER(a_slot_zero, (state_q == S_UP_RD || state_q == S_DN_L) && slot_q == '0)

endmodule

// ===== src/binary_min_heap_queue.sv =====
// Each accepted command word gives one result word. Insert sifts the key up;
// delete moves the last key to the root and sifts it down; read-minimum,
// full, empty and unknown commands move no keys. A new command word is taken
// only when the sequencer is idle, since the single-read store and the shared
// comparator serve one command; a waiting result stalls only the next finish.
// Reset: asynchronous, active low; clears the count, capacity to 255.
module binary_min_heap_queue #(
  parameter int unsigned MAX_ENTRIES = 255,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmhq_cmd_if.sink    cmd_i,
  bmhq_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import bmhq_pkg::*;

  logic [7:0]           cap_q;
  bmhq_req_t            req;
  bmhq_stat_t           stat;
  logic [KEY_WIDTH-1:0] eng_min;
  logic [7:0]           eng_count;

  logic                 res_valid_q, res_valid_d;
  status_t              res_status_q;
  logic [KEY_WIDTH-1:0] res_min_q;
  logic [7:0]           res_count_q;
  logic                 res_load;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // take a command word whenever the sequencer is idle
  assign cmd_i.ready  = stat.idle;
  assign req.start    = cmd_i.valid & stat.idle;
  assign req.command  = cmd_i.command;
  assign req.res_take = !res_valid_q || res_o.ready;

  bmhq_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .key_i         (cmd_i.value),
    .cap_i         (cap_q),
    .stat_o        (stat),
    .min_value_o   (eng_min),
    .entry_count_o (eng_count)
  );

  // output register: load a finished result, drop it once taken
  assign res_load = stat.done && req.res_take;

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q <= stat.status;
      res_min_q    <= eng_min;
      res_count_q  <= eng_count;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.status      = res_status_q;
  assign res_o.min_value   = res_min_q;
  assign res_o.entry_count = res_count_q;

endmodule
